>>> rtl/lr_parse_driver_core_defines.svh
// assertion macros used by lrp_checker
`ifndef LR_PARSE_DRIVER_CORE_DEFINES_SVH
`define LR_PARSE_DRIVER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LRP_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("lrp check failed");

// next-cycle implication, disabled while reset is asserted
`define LRP_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("lrp check failed");

`endif

>>> rtl/lrp_pkg.sv
// shared types, codes and defaults for the lr parse driver
package lrp_pkg;

	localparam int NUM_STATES_DEF  = 256;
	localparam int NUM_SYMBOLS_DEF = 64;
	localparam int NUM_PRODS_DEF   = 256;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int MAX_CHAIN_DEF   = 32;

	localparam logic [1:0] REQ_TOKEN   = 2'd0;
	localparam logic [1:0] REQ_ENTRY   = 2'd1;
	localparam logic [1:0] REQ_PROD    = 2'd2;
	localparam logic [1:0] REQ_RESTART = 2'd3;

	localparam logic [2:0] K_EMPTY  = 3'd0;
	localparam logic [2:0] K_SHIFT  = 3'd1;
	localparam logic [2:0] K_REDUCE = 3'd2;
	localparam logic [2:0] K_ACCEPT = 3'd3;
	localparam logic [2:0] K_GOTO   = 3'd4;

	localparam logic [1:0] EV_SHIFT  = 2'd0;
	localparam logic [1:0] EV_REDUCE = 2'd1;
	localparam logic [1:0] EV_ACCEPT = 2'd2;
	localparam logic [1:0] EV_ERROR  = 2'd3;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_ACTION = 3'd1;
	localparam logic [2:0] ERR_NO_GOTO   = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd4;
	localparam logic [2:0] ERR_CHAIN     = 3'd5;

	typedef struct packed {
		logic [1:0] req_type;
		logic [5:0] token_id;
		logic [7:0] entry_state;
		logic [5:0] entry_symbol;
		logic [2:0] entry_kind;
		logic [7:0] entry_target;
		logic [7:0] prod_number;
		logic [5:0] prod_lhs;
		logic [3:0] prod_length;
	} req_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] new_state;
		logic [7:0] reduced_prod;
		logic [5:0] reduced_symbol;
		logic [6:0] stack_level;
		logic [2:0] error_code;
		logic       last;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACT,
		S_PROD,
		S_STK,
		S_GOTO
	} lrp_state_t;

	function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] st,
			input logic [7:0] prod, input logic [5:0] sym, input logic [6:0] lvl,
			input logic [2:0] err, input logic lst);
		result_t r;
		r.event_kind     = kind;
		r.new_state      = st;
		r.reduced_prod   = prod;
		r.reduced_symbol = sym;
		r.stack_level    = lvl;
		r.error_code     = err;
		r.last           = lst;
		return r;
	endfunction

endpackage

>>> rtl/lrp_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/lr_parse_driver_core.sv
// lr parse driver: table-driven shift-reduce parser around three rams
// Usage: drive req and pulse start while busy is low; a beat is taken at that
// edge. Request types load an action/goto entry, load a production, restart
// the parser or present a token. Loads and restart finish in the cycle they
// are taken and give no result. A token runs the lr loop and gives one or
// more results, each shown for one cycle with result_valid high; the final
// one of the token carries result.last, but a token taken after an accept
// or halt is dropped with no result until a restart. The receiver cannot
// stall. A token is looked up in the action ram, then a shift, accept or
// action error result is registered; each reduce is paced by the reads of
// the action ram, production ram and state stack ram in turn (the stack
// read is skipped when its length is zero). busy drops in the cycle the
// last result is shown. Reset: the action ram is swept to empty, one entry
// a cycle, through all NUM_STATES * 2**clog2(NUM_SYMBOLS) entries (16384 by
// default) with busy high; the stack holds state 0, level 1, and both flags
// are clear. The production ram is undefined until loaded.
module lr_parse_driver_core
	import lrp_pkg::*;
#(
	parameter int NUM_STATES  = NUM_STATES_DEF,
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	parameter int NUM_PRODS   = NUM_PRODS_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int MAX_CHAIN   = MAX_CHAIN_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  req_t    req,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);
	localparam int STW    = $clog2(NUM_STATES);
	localparam int SW     = $clog2(NUM_SYMBOLS);
	localparam int ATW    = STW + SW;
	localparam int ADEPTH = NUM_STATES * (1 << SW);
	localparam int PW     = (NUM_PRODS > 1) ? $clog2(NUM_PRODS) : 1;
	localparam int PDEPTH = (NUM_PRODS > 1) ? NUM_PRODS : 2;
	localparam int SIW    = $clog2(STACK_DEPTH);
	localparam int SPW    = $clog2(STACK_DEPTH + 1);

	lrp_state_t state_q, state_d;
	logic [ATW-1:0] clr_q, clr_d;
	logic [SPW-1:0] sp_q, sp_d, spn_q, spn_d;
	logic [7:0]     top_q, top_d, tgt_q, tgt_d;
	logic [5:0]     tok_q, tok_d, lhs_q, lhs_d, chain_q, chain_d;
	logic           acc_q, acc_d, halt_q, halt_d, oor_q, oor_d;
	logic           res_valid_q, res_valid_d;
	result_t        res_q, res_d;

	logic           act_we;
	logic [ATW-1:0] act_waddr, act_raddr;
	logic [10:0]    act_wdata, act_rdata;
	logic           prod_we;
	logic [PW-1:0]  prod_waddr, prod_raddr;
	logic [9:0]     prod_rdata;
	logic           stk_we;
	logic [SIW-1:0] stk_waddr, stk_raddr;
	logic [7:0]     stk_wdata, stk_rdata;

	logic [2:0]     act_kind;
	logic [10:0]    len_w, sp_w, spn_w;

	function automatic logic [ATW-1:0] aidx(input logic [7:0] st, input logic [5:0] sym);
		logic [11:0] st_x;
		logic [9:0]  sym_x;
		st_x  = {4'd0, st};
		sym_x = {4'd0, sym};
		return {st_x[STW-1:0], sym_x[SW-1:0]};
	endfunction

	function automatic logic aok(input logic [7:0] st, input logic [5:0] sym);
		return ({5'd0, st} < 13'(NUM_STATES)) && ({5'd0, sym} < 11'(NUM_SYMBOLS));
	endfunction

	function automatic logic pok(input logic [7:0] p);
		return {5'd0, p} < 13'(NUM_PRODS);
	endfunction

	function automatic logic [PW-1:0] pidx(input logic [7:0] p);
		logic [11:0] p_x;
		p_x = {4'd0, p};
		return p_x[PW-1:0];
	endfunction

	lrp_ram #(.WIDTH(11), .DEPTH(ADEPTH)) u_act_ram (
		.clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
		.raddr(act_raddr), .rdata(act_rdata)
	);

	lrp_ram #(.WIDTH(10), .DEPTH(PDEPTH)) u_prod_ram (
		.clk(clk), .we(prod_we), .waddr(prod_waddr), .wdata({req.prod_lhs, req.prod_length}),
		.raddr(prod_raddr), .rdata(prod_rdata)
	);

	lrp_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign act_kind = oor_q ? K_EMPTY : act_rdata[10:8];
	assign len_w    = {7'd0, prod_rdata[3:0]};
	assign sp_w     = 11'(sp_q);
	assign spn_w    = sp_w - len_w;

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		sp_d        = sp_q;
		spn_d       = spn_q;
		top_d       = top_q;
		tgt_d       = tgt_q;
		tok_d       = tok_q;
		lhs_d       = lhs_q;
		chain_d     = chain_q;
		acc_d       = acc_q;
		halt_d      = halt_q;
		oor_d       = oor_q;
		res_valid_d = 1'b0;
		res_d       = res_q;
		act_we      = 1'b0;
		act_waddr   = aidx(req.entry_state, req.entry_symbol);
		act_wdata   = {(req.entry_kind > K_GOTO) ? K_EMPTY : req.entry_kind, req.entry_target};
		act_raddr   = aidx(top_q, req.token_id);
		prod_we     = 1'b0;
		prod_waddr  = pidx(req.prod_number);
		prod_raddr  = pidx(act_rdata[7:0]);
		stk_we      = 1'b0;
		stk_waddr   = SIW'(sp_q);
		stk_wdata   = act_rdata[7:0];
		stk_raddr   = SIW'(spn_w - 11'd1);

		unique case (state_q)
			S_CLEAR: begin
				act_we    = 1'b1;
				act_waddr = clr_q;
				act_wdata = '0;
				if (clr_q == '0) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = '0;
				end
				clr_d = clr_q + 1'b1;
				if (clr_q == ATW'(ADEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (req.req_type)
						REQ_TOKEN: begin
							if (!acc_q && !halt_q) begin
								tok_d   = req.token_id;
								oor_d   = !aok(top_q, req.token_id);
								chain_d = '0;
								state_d = S_ACT;
							end
						end
						REQ_ENTRY: begin
							act_we = aok(req.entry_state, req.entry_symbol);
						end
						REQ_PROD: begin
							prod_we = pok(req.prod_number);
						end
						REQ_RESTART: begin
							sp_d   = SPW'(1);
							top_d  = '0;
							acc_d  = 1'b0;
							halt_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			S_ACT: begin
				tgt_d       = act_rdata[7:0];
				state_d     = S_IDLE;
				res_valid_d = 1'b1;
				res_d = make_result(EV_ERROR, top_q, 8'd0, 6'd0, 7'(sp_q), ERR_NO_ACTION, 1'b1);
				priority if (act_kind == K_SHIFT) begin
					if (sp_q >= SPW'(STACK_DEPTH)) begin
						halt_d = 1'b1;
						res_d.error_code = ERR_OVERFLOW;
					end else begin
						stk_we = 1'b1;
						top_d  = act_rdata[7:0];
						sp_d   = sp_q + 1'b1;
						res_d  = make_result(EV_SHIFT, act_rdata[7:0], 8'd0, 6'd0,
							7'(sp_q + 1'b1), ERR_NONE, 1'b1);
					end
				end else if (act_kind == K_ACCEPT) begin
					acc_d = 1'b1;
					res_d = make_result(EV_ACCEPT, top_q, 8'd0, 6'd0, 7'(sp_q), ERR_NONE, 1'b1);
				end else if (act_kind == K_REDUCE && chain_q >= 6'(MAX_CHAIN)) begin
					halt_d = 1'b1;
					res_d.error_code = ERR_CHAIN;
				end else if (act_kind == K_REDUCE && pok(act_rdata[7:0])) begin
					// production read issued, no result this cycle
					res_valid_d = 1'b0;
					state_d     = S_PROD;
				end else begin
					halt_d = 1'b1;
				end
			end
			S_PROD: begin
				lhs_d = prod_rdata[9:4];
				spn_d = SPW'(spn_w);
				oor_d = !aok(top_q, prod_rdata[9:4]);
				act_raddr = aidx(top_q, prod_rdata[9:4]);
				if (len_w >= sp_w) begin
					halt_d      = 1'b1;
					state_d     = S_IDLE;
					res_valid_d = 1'b1;
					res_d = make_result(EV_ERROR, top_q, 8'd0, 6'd0, 7'(sp_q),
						ERR_UNDERFLOW, 1'b1);
				end else if (len_w == '0) begin
					state_d = S_GOTO;
				end else begin
					state_d = S_STK;
				end
			end
			S_STK: begin
				oor_d     = !aok(stk_rdata, lhs_q);
				act_raddr = aidx(stk_rdata, lhs_q);
				state_d   = S_GOTO;
			end
			S_GOTO: begin
				res_valid_d = 1'b1;
				if (oor_q || act_rdata[10:8] != K_GOTO) begin
					halt_d  = 1'b1;
					state_d = S_IDLE;
					res_d = make_result(EV_ERROR, top_q, 8'd0, 6'd0, 7'(sp_q), ERR_NO_GOTO, 1'b1);
				end else if (spn_q >= SPW'(STACK_DEPTH)) begin
					halt_d  = 1'b1;
					state_d = S_IDLE;
					res_d = make_result(EV_ERROR, top_q, 8'd0, 6'd0, 7'(sp_q), ERR_OVERFLOW, 1'b1);
				end else begin
					// push goto state, then look at the same token again
					stk_we    = 1'b1;
					stk_waddr = SIW'(spn_q);
					top_d     = act_rdata[7:0];
					sp_d      = spn_q + 1'b1;
					chain_d   = chain_q + 1'b1;
					oor_d     = !aok(act_rdata[7:0], tok_q);
					act_raddr = aidx(act_rdata[7:0], tok_q);
					state_d   = S_ACT;
					res_d = make_result(EV_REDUCE, act_rdata[7:0], tgt_q, lhs_q,
						7'(spn_q + 1'b1), ERR_NONE, 1'b0);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			sp_q        <= SPW'(1);
			top_q       <= '0;
			acc_q       <= 1'b0;
			halt_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			sp_q        <= sp_d;
			top_q       <= top_d;
			acc_q       <= acc_d;
			halt_q      <= halt_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		spn_q   <= spn_d;
		tgt_q   <= tgt_d;
		tok_q   <= tok_d;
		lhs_q   <= lhs_d;
		chain_q <= chain_d;
		oor_q   <= oor_d;
		res_q   <= res_d;
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
endmodule

>>> rtl/lrp_checker.sv
// port-level checks for the lr parse driver, bound to the top level
`include "lr_parse_driver_core_defines.svh"

module lrp_checker
	import lrp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input req_t    req,
	input logic    busy,
	input logic    result_valid,
	input result_t result
);
	// more beats of the same token follow, so the block stays busy
	`LRP_ASSERT_NOW(a_more_busy, clk, arst_n, result_valid && !result.last, busy)
	// final beat is never directly followed by another
	`LRP_ASSERT_NEXT(a_last_gap, clk, arst_n, result_valid && result.last, !result_valid)
	// loads and restart give no result
	`LRP_ASSERT_NEXT(a_load_quiet, clk, arst_n,
		start && !busy && req.req_type != REQ_TOKEN, !result_valid)
	// errors and shifts end the token
	`LRP_ASSERT_NOW(a_err_last, clk, arst_n,
		result_valid && (result.event_kind == EV_ERROR || result.event_kind == EV_SHIFT),
		result.last)
	`LRP_ASSERT_NOW(a_err_code, clk, arst_n,
		result_valid && result.event_kind != EV_ERROR, result.error_code == ERR_NONE)
endmodule

bind lr_parse_driver_core lrp_checker u_lrp_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
	.result_valid(result_valid), .result(result)
);

>>> bench/lr_parse_driver_core_test.sv
// testbench for the lr parse driver: random parse tables and tokens against a scoreboard
`timescale 1ns / 100ps

module lr_parse_driver_core_test;
	import lrp_pkg::*;

	class lr_scoreboard;
		logic [10:0] actions [16384];
		logic [9:0]  prods [256];
		logic [7:0]  states [64];
		int          level;
		bit          accepted;
		bit          halted;
		result_t     pending [$];
		int          mismatches;

		function new();
			foreach (actions[i]) actions[i] = '0;
			foreach (prods[i]) prods[i] = '0;
			clear_stack();
			mismatches = 0;
		endfunction

		function void clear_stack();
			foreach (states[i]) states[i] = '0;
			level = 1;
			accepted = 0;
			halted = 0;
		endfunction

		function void add_event(logic [1:0] kind, logic [7:0] prod, logic [5:0] sym,
				logic [2:0] err);
			result_t r;
			r.event_kind     = kind;
			r.new_state      = states[level - 1];
			r.reduced_prod   = prod;
			r.reduced_symbol = sym;
			r.stack_level    = level[6:0];
			r.error_code     = err;
			r.last           = 1'b0;
			pending.push_back(r);
		endfunction

		// work out what one accepted beat should produce
		function void note(req_t r);
			logic [7:0]  top;
			logic [10:0] act;
			logic [10:0] go;
			logic [5:0]  lhs;
			int          len;
			int          base;
			int          chain;
			logic [2:0]  err;
			chain = 0;
			case (r.req_type)
				REQ_ENTRY: begin
					actions[{r.entry_state, r.entry_symbol}] =
						{(r.entry_kind > K_GOTO) ? K_EMPTY : r.entry_kind, r.entry_target};
					return;
				end
				REQ_PROD: begin
					prods[r.prod_number] = {r.prod_lhs, r.prod_length};
					return;
				end
				REQ_RESTART: begin
					clear_stack();
					return;
				end
				default: ;
			endcase
			if (accepted || halted)
				return;
			while (1) begin
				top = states[level - 1];
				act = actions[{top, r.token_id}];
				err = ERR_NONE;
				if (act[10:8] == K_SHIFT) begin
					if (level >= 64) err = ERR_OVERFLOW;
					else begin
						states[level] = act[7:0];
						level++;
						add_event(EV_SHIFT, '0, '0, ERR_NONE);
						break;
					end
				end else if (act[10:8] == K_ACCEPT) begin
					accepted = 1;
					add_event(EV_ACCEPT, '0, '0, ERR_NONE);
					break;
				end else if (act[10:8] == K_REDUCE) begin
					lhs = prods[act[7:0]][9:4];
					len = int'(prods[act[7:0]][3:0]);
					if (chain >= 32) err = ERR_CHAIN;
					else if (len >= level) err = ERR_UNDERFLOW;
					else begin
						base = level - len;
						go = actions[{states[base - 1], lhs}];
						if (go[10:8] != K_GOTO) err = ERR_NO_GOTO;
						else if (base >= 64) err = ERR_OVERFLOW;
						else begin
							states[base] = go[7:0];
							level = base + 1;
							chain++;
							add_event(EV_REDUCE, act[7:0], lhs, ERR_NONE);
							continue;
						end
					end
				end else err = ERR_NO_ACTION;
				halted = 1;
				add_event(EV_ERROR, '0, '0, err);
				break;
			end
			pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void check(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			want = pending.pop_front();
			if (got.event_kind !== want.event_kind || got.new_state !== want.new_state ||
					got.reduced_prod !== want.reduced_prod ||
					got.reduced_symbol !== want.reduced_symbol ||
					got.stack_level !== want.stack_level ||
					got.error_code !== want.error_code || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	req_t    req;
	logic    busy;
	logic    result_valid;
	result_t result;

	lr_scoreboard sb;

	lr_parse_driver_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check(result);
	end

	// drive one beat, hold it until the block takes it
	task automatic send(req_t r);
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		n = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		sb.note(r);
	endtask

	function automatic req_t noise();
		req_t        r;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		r = bits[$bits(req_t)-1:0];
		return r;
	endfunction

	task automatic load_entry(logic [7:0] st, logic [5:0] sym, logic [2:0] kind,
			logic [7:0] tgt);
		req_t r;
		r = noise();
		r.req_type = REQ_ENTRY;
		r.entry_state = st;
		r.entry_symbol = sym;
		r.entry_kind = kind;
		r.entry_target = tgt;
		send(r);
	endtask

	task automatic load_prod(logic [7:0] p, logic [5:0] lhs, logic [3:0] len);
		req_t r;
		r = noise();
		r.req_type = REQ_PROD;
		r.prod_number = p;
		r.prod_lhs = lhs;
		r.prod_length = len;
		send(r);
	endtask

	task automatic token(logic [5:0] t);
		req_t r;
		r = noise();
		r.req_type = REQ_TOKEN;
		r.token_id = t;
		send(r);
	endtask

	task automatic restart_parser();
		req_t r;
		r = noise();
		r.req_type = REQ_RESTART;
		send(r);
	endtask

	initial begin
		int     items;
		int     pick;
		int     k;
		req_t   r;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: shift, reduce with goto, accept, then the no-action, underflow, no-goto and chain errors
		load_prod(8'd0, 6'd63, 4'd1);
		load_prod(8'd1, 6'd62, 4'd0);
		load_prod(8'd2, 6'd61, 4'd8);
		load_prod(8'd255, 6'd0, 4'd2);
		load_entry(8'd0, 6'd1, K_SHIFT, 8'd5);
		load_entry(8'd5, 6'd2, K_REDUCE, 8'd0);
		load_entry(8'd0, 6'd63, K_GOTO, 8'd7);
		load_entry(8'd7, 6'd2, K_ACCEPT, 8'd0);
		token(6'd1);
		token(6'd2);
		token(6'd2);
		restart_parser();
		token(6'd63);
		restart_parser();
		load_entry(8'd0, 6'd3, K_REDUCE, 8'd2);
		token(6'd3);
		restart_parser();
		load_entry(8'd0, 6'd4, K_REDUCE, 8'd1);
		token(6'd4);
		restart_parser();
		// zero-length reduce that loops on itself runs into the chain limit
		load_entry(8'd0, 6'd62, K_GOTO, 8'd0);
		token(6'd4);
		restart_parser();
		load_entry(8'd255, 6'd63, 3'd7, 8'd255);

		// productions used by random reduce entries
		for (k = 3; k < 16; k++)
			load_prod(k[7:0], 6'($urandom_range(60, 63)), 4'($urandom_range(0, 3)));

		items = 0;
		while (items < 350) begin
			pick = $urandom_range(0, 99);
			r = noise();
			if ((sb.accepted || sb.halted) && $urandom_range(0, 9) < 7) begin
				r.req_type = REQ_RESTART;
			end else if (pick < 6) begin
				r.req_type = REQ_RESTART;
			end else if (pick < 22) begin
				r.req_type = REQ_ENTRY;
				r.entry_state = 8'($urandom_range(0, 7));
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					r.entry_kind = K_SHIFT;
					r.entry_target = 8'($urandom_range(0, 7));
				end else if (pick < 60) begin
					r.entry_kind = K_REDUCE;
					r.entry_target = 8'($urandom_range(0, 15));
				end else if (pick < 85) begin
					r.entry_kind = K_GOTO;
					r.entry_target = 8'($urandom_range(0, 7));
				end else if (pick < 90) begin
					r.entry_kind = K_ACCEPT;
				end else if (pick < 95) begin
					r.entry_kind = K_EMPTY;
				end else begin
					r.entry_kind = 3'($urandom_range(5, 7));
				end
				r.entry_symbol = (r.entry_kind == K_GOTO) ? 6'($urandom_range(60, 63))
					: 6'($urandom_range(0, 7));
			end else if (pick < 25) begin
				// anywhere in the table; reduce only names loaded productions
				r.req_type = REQ_ENTRY;
				if (r.entry_kind == K_REDUCE)
					r.entry_target[7:4] = '0;
			end else if (pick < 29) begin
				r.req_type = REQ_PROD;
				r.prod_length = $urandom_range(0, 99) < 85 ? 4'($urandom_range(0, 2))
					: 4'($urandom_range(3, 8));
				if ($urandom_range(0, 3) != 0)
					r.prod_lhs = 6'($urandom_range(60, 63));
			end else begin
				r.req_type = REQ_TOKEN;
				if ($urandom_range(0, 9) != 0)
					r.token_id = 6'($urandom_range(0, 7));
			end
			if (!(r.req_type == REQ_TOKEN && (sb.accepted || sb.halted)))
				items++;
			send(r);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
